// ===== rtl/core/cidlp_pkg.sv =====
// Shared types and constants for the caller-ID line parser.
// No dependencies; imported by every module of the block but cidlp_ram.
`timescale 1ns / 1ps

package cidlp_pkg;

  // fixed field widths of the stream payload and the line length counter
  localparam int unsigned ByteW       = 8;
  localparam int unsigned LineIdW     = 5;
  localparam int unsigned TextW       = 32;
  localparam int unsigned TextLenW    = 3;
  localparam int unsigned NumLenW     = 4;
  localparam int unsigned NameLenW    = 6;
  localparam int unsigned ItemKindW   = 2;
  localparam int unsigned OutDataW    = 96;
  localparam int unsigned LineLenW    = 8;

  // default store sizes
  localparam int unsigned NumberCharsDef = 14;
  localparam int unsigned NameCharsDef   = 49;

  localparam logic [LineIdW-1:0] LineIdReset = 5'd1;

  // characters with a special meaning
  localparam logic [ByteW-1:0] CharLf    = 8'd10;
  localparam logic [ByteW-1:0] CharNul   = 8'd0;
  localparam logic [ByteW-1:0] CharSpace = 8'd32;
  localparam logic [ByteW-1:0] CharEqual = 8'd61;
  localparam logic [ByteW-1:0] CharOne   = 8'h31;
  localparam logic [ByteW-1:0] CharCr    = 8'd13;

  // line keywords, first byte in the high bits
  localparam logic [31:0] WordDate = 32'h4441_5445;
  localparam logic [31:0] WordTime = 32'h5449_4D45;
  localparam logic [31:0] WordNmbr = 32'h4E4D_4252;
  localparam logic [31:0] WordName = 32'h4E41_4D45;

  // item kinds on tuser
  localparam logic [ItemKindW-1:0] ItemHeader = 2'd0;
  localparam logic [ItemKindW-1:0] ItemNumber = 2'd1;
  localparam logic [ItemKindW-1:0] ItemName   = 2'd2;

  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_DATE = 3'd1,
    KIND_TIME = 3'd2,
    KIND_NMBR = 3'd3,
    KIND_NAME = 3'd4
  } line_kind_e;

  // output tdata layout, msb member first
  typedef struct packed {
    logic [2:0]          pad;
    logic [ByteW-1:0]    text_char;
    logic [NameLenW-1:0] name_length;
    logic [NumLenW-1:0]  number_length;
    logic [TextLenW-1:0] time_length;
    logic [TextW-1:0]    time_text;
    logic [TextLenW-1:0] date_length;
    logic [TextW-1:0]    date_text;
    logic [LineIdW-1:0]  line_number;
  } out_data_t;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic accept;
    logic load_hdr;
    logic rd_num;
    logic rd_name;
    logic load_num;
    logic load_name;
    logic idx_clr;
    logic idx_inc;
    logic clear_fields;
  } dp_cmd_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic rec_end;
    logic out_free;
    logic num_any;
    logic name_any;
    logic num_more;
    logic name_more;
  } dp_status_t;

endpackage

// ===== rtl/core/caller_id_line_parser.sv =====
// Caller-ID line parser: usage and handshake.
// Input stream s_axis carries one modem text byte per transfer. Bytes build
// lines ending at LF or NUL; DATE, TIME, NMBR and NAME lines fill fields.
// Output stream m_axis carries one record per NAME line: a header (tuser 0)
// with line id, date, time and lengths, then number characters (tuser 1),
// then name characters (tuser 2); tlast marks the final item of a record.
// cfg_we_i/cfg_wdata_i write the line id (reset 1); the user must do so only
// while the block is idle, as the block itself does not enforce it.
// Throughput: one input byte per cycle outside record emission. The byte
// that ends a NAME line starts emission and tready drops; the header is
// loaded once the output register is free, then each character passes a
// read state and a load state because of the registered read of the
// number/name RAMs. An item is visible in the cycle after it is loaded.
// A receiver stall holds the output register; the sequencer waits and input
// stays stalled until the last item of the record is loaded. Input bytes
// are taken again while that last item still waits for its transfer.
// Reset clears all parsing state and fields; character RAMs are not cleared.
// Depends on cidlp_pkg, cidlp_ctrl, cidlp_datapath and cidlp_ram.
`timescale 1ns / 1ps

module caller_id_line_parser #(
  parameter int unsigned NumberChars = cidlp_pkg::NumberCharsDef,
  parameter int unsigned NameChars   = cidlp_pkg::NameCharsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // line id register write
  input  logic                              cfg_we_i,
  input  logic [cidlp_pkg::LineIdW-1:0]     cfg_wdata_i,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [cidlp_pkg::ByteW-1:0]       s_axis_tdata,   // rx_byte
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // line_number, date_text, date_length, time_text, time_length,
  // number_length, name_length, text_char, zero fill
  output logic [cidlp_pkg::OutDataW-1:0]    m_axis_tdata,
  output logic [cidlp_pkg::ItemKindW-1:0]   m_axis_tuser,   // item_kind
  output logic                              m_axis_tlast    // last_of_record
);

  import cidlp_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // sequencer
  cidlp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  // datapath
  cidlp_datapath #(
    .NumberChars (NumberChars),
    .NameChars   (NameChars)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_byte_i   (s_axis_tdata),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_kind_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  // a byte ending a NAME line stops further input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_cmd.accept && dp_status.rec_end) |=> !s_axis_tready)
    else $error("input not stalled after record end");

  // never overwrite an item that has not been transferred
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_cmd.load_hdr || dp_cmd.load_num || dp_cmd.load_name) |-> dp_status.out_free)
    else $error("output register overwritten");

  // input transfer and item loads are exclusive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({dp_cmd.accept, dp_cmd.load_hdr, dp_cmd.load_num, dp_cmd.load_name}))
    else $error("conflicting datapath commands");

endmodule

// ===== rtl/core/cidlp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cidlp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/cidlp_datapath.sv =====
// Datapath of the caller-ID line parser: line tracking, field stores,
// emit index and output register. Uses cidlp_pkg and cidlp_ram.
`timescale 1ns / 1ps

module cidlp_datapath #(
  parameter int unsigned NumberChars = cidlp_pkg::NumberCharsDef,
  parameter int unsigned NameChars   = cidlp_pkg::NameCharsDef
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        cfg_we_i,
  input  logic [cidlp_pkg::LineIdW-1:0]               cfg_wdata_i,
  input  logic [cidlp_pkg::ByteW-1:0]                 rx_byte_i,
  input  cidlp_pkg::dp_cmd_t                          cmd_i,
  output cidlp_pkg::dp_status_t                       status_o,
  input  logic                                        out_ready_i,
  output logic                                        out_valid_o,
  output logic [cidlp_pkg::OutDataW-1:0]              out_data_o,
  output logic [cidlp_pkg::ItemKindW-1:0]             out_kind_o,
  output logic                                        out_last_o
);

  import cidlp_pkg::*;

  localparam int unsigned NumCntW  = $clog2(NumberChars + 1);
  localparam int unsigned NameCntW = $clog2(NameChars + 1);
  localparam int unsigned NumAw    = (NumberChars > 1) ? $clog2(NumberChars) : 1;
  localparam int unsigned NameAw   = (NameChars > 1) ? $clog2(NameChars) : 1;
  localparam int unsigned IdxW     = (NumCntW > NameCntW) ? NumCntW : NameCntW;

  logic [LineIdW-1:0]  line_id_q;
  logic [LineLenW-1:0] line_len_q, line_len_d;
  logic [23:0]         kw_q, kw_d;
  line_kind_e          kind_q, kind_d;
  logic                phase_q, phase_d;
  logic [TextW-1:0]    date_q, date_d, time_q, time_d;
  logic [TextLenW-1:0] date_cnt_q, date_cnt_d, time_cnt_q, time_cnt_d;
  logic [NumCntW-1:0]  num_cnt_q, num_cnt_d, num_kept_q, num_kept_d;
  logic [NameCntW-1:0] name_cnt_q, name_cnt_d, name_kept_q, name_kept_d;
  logic [IdxW-1:0]     idx_q;
  logic [IdxW:0]       idx_next;
  logic                num_we, name_we;
  logic [ByteW-1:0]    num_rdata, name_rdata;
  logic                is_end, is_sep, is_blank;

  logic                out_valid_q;
  out_data_t           out_data_q;
  logic [ItemKindW-1:0] out_kind_q;
  logic                out_last_q;
  out_data_t           hdr_data, chr_data;

  // byte classification
  assign is_end   = (rx_byte_i == CharLf) || (rx_byte_i == CharNul);
  assign is_sep   = (rx_byte_i == CharSpace) || (rx_byte_i == CharEqual);
  assign is_blank = (rx_byte_i == CharSpace) || (rx_byte_i == CharCr);

  // line id register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_id_q <= LineIdReset;
    end else if (cfg_we_i) begin
      line_id_q <= cfg_wdata_i;
    end
  end

  // line parsing and field capture
  always_comb begin
    line_len_d  = line_len_q;
    kw_d        = kw_q;
    kind_d      = kind_q;
    phase_d     = phase_q;
    date_d      = date_q;
    date_cnt_d  = date_cnt_q;
    time_d      = time_q;
    time_cnt_d  = time_cnt_q;
    num_cnt_d   = num_cnt_q;
    num_kept_d  = num_kept_q;
    name_cnt_d  = name_cnt_q;
    name_kept_d = name_kept_q;
    num_we      = 1'b0;
    name_we     = 1'b0;

    if (cmd_i.clear_fields) begin
      date_d      = '0;
      date_cnt_d  = '0;
      time_d      = '0;
      time_cnt_d  = '0;
      num_cnt_d   = '0;
      num_kept_d  = '0;
      name_cnt_d  = '0;
      name_kept_d = '0;
    end

    if (cmd_i.accept) begin
      if (is_end) begin
        line_len_d = '0;
        kw_d       = '0;
        kind_d     = KIND_NONE;
        phase_d    = 1'b0;
      end else begin
        if (line_len_q < LineLenW'(3)) begin
          kw_d = {kw_q[15:0], rx_byte_i};
        end else if (line_len_q == LineLenW'(3)) begin
          // fourth byte completes the keyword
          phase_d = 1'b0;
          case ({kw_q, rx_byte_i})
            WordDate: begin
              kind_d     = KIND_DATE;
              date_d     = '0;
              date_cnt_d = '0;
            end
            WordTime: begin
              kind_d     = KIND_TIME;
              time_d     = '0;
              time_cnt_d = '0;
            end
            WordNmbr: begin
              kind_d     = KIND_NMBR;
              num_cnt_d  = '0;
              num_kept_d = '0;
            end
            WordName: begin
              kind_d      = KIND_NAME;
              name_cnt_d  = '0;
              name_kept_d = '0;
            end
            default: kind_d = KIND_NONE;
          endcase
        end else if ((kind_q != KIND_NONE) && !(!phase_q && is_sep)) begin
          // field body, separators already skipped
          phase_d = 1'b1;
          if (!(!phase_q && (kind_q == KIND_NMBR) && (rx_byte_i == CharOne))) begin
            case (kind_q)
              KIND_DATE: begin
                if (date_cnt_q < TextLenW'(4)) begin
                  date_d[{~date_cnt_q[1:0], 3'b000} +: ByteW] = rx_byte_i;
                  date_cnt_d = date_cnt_q + TextLenW'(1);
                end
              end
              KIND_TIME: begin
                if (time_cnt_q < TextLenW'(4)) begin
                  time_d[{~time_cnt_q[1:0], 3'b000} +: ByteW] = rx_byte_i;
                  time_cnt_d = time_cnt_q + TextLenW'(1);
                end
              end
              KIND_NMBR: begin
                if (num_cnt_q < NumCntW'(NumberChars)) begin
                  num_we    = 1'b1;
                  num_cnt_d = num_cnt_q + NumCntW'(1);
                  if (!is_blank) begin
                    num_kept_d = num_cnt_q + NumCntW'(1);
                  end
                end
              end
              KIND_NAME: begin
                if (name_cnt_q < NameCntW'(NameChars)) begin
                  name_we    = 1'b1;
                  name_cnt_d = name_cnt_q + NameCntW'(1);
                  if (!is_blank) begin
                    name_kept_d = name_cnt_q + NameCntW'(1);
                  end
                end
              end
              default: ;
            endcase
          end
        end
        if (line_len_q != {LineLenW{1'b1}}) begin
          line_len_d = line_len_q + LineLenW'(1);
        end
      end
    end
  end

  // parser and field state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_len_q  <= '0;
      kw_q        <= '0;
      kind_q      <= KIND_NONE;
      phase_q     <= 1'b0;
      date_q      <= '0;
      date_cnt_q  <= '0;
      time_q      <= '0;
      time_cnt_q  <= '0;
      num_cnt_q   <= '0;
      num_kept_q  <= '0;
      name_cnt_q  <= '0;
      name_kept_q <= '0;
    end else begin
      line_len_q  <= line_len_d;
      kw_q        <= kw_d;
      kind_q      <= kind_d;
      phase_q     <= phase_d;
      date_q      <= date_d;
      date_cnt_q  <= date_cnt_d;
      time_q      <= time_d;
      time_cnt_q  <= time_cnt_d;
      num_cnt_q   <= num_cnt_d;
      num_kept_q  <= num_kept_d;
      name_cnt_q  <= name_cnt_d;
      name_kept_q <= name_kept_d;
    end
  end

  // number and name character stores
  cidlp_ram #(
    .Width (ByteW),
    .Depth (NumberChars)
  ) u_num_ram (
    .clk_i   (clk_i),
    .we_i    (num_we),
    .waddr_i (num_cnt_q[NumAw-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (cmd_i.rd_num),
    .raddr_i (idx_q[NumAw-1:0]),
    .rdata_o (num_rdata)
  );

  cidlp_ram #(
    .Width (ByteW),
    .Depth (NameChars)
  ) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (name_we),
    .waddr_i (name_cnt_q[NameAw-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (cmd_i.rd_name),
    .raddr_i (idx_q[NameAw-1:0]),
    .rdata_o (name_rdata)
  );

  // emit index over the stored characters
  assign idx_next = {1'b0, idx_q} + (IdxW + 1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_next[IdxW-1:0];
    end
  end

  // status toward the sequencer
  assign status_o.rec_end   = is_end && (line_len_q != '0) && (kind_q == KIND_NAME);
  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign status_o.num_any   = (num_kept_q != '0);
  assign status_o.name_any  = (name_kept_q != '0);
  assign status_o.num_more  = idx_next < (IdxW + 1)'(num_kept_q);
  assign status_o.name_more = idx_next < (IdxW + 1)'(name_kept_q);

  // header and character payloads
  always_comb begin
    hdr_data               = '0;
    hdr_data.line_number   = line_id_q;
    hdr_data.date_text     = date_q;
    hdr_data.date_length   = date_cnt_q;
    hdr_data.time_text     = time_q;
    hdr_data.time_length   = time_cnt_q;
    hdr_data.number_length = NumLenW'(num_kept_q);
    hdr_data.name_length   = NameLenW'(name_kept_q);
    chr_data               = '0;
    chr_data.text_char     = cmd_i.load_num ? num_rdata : name_rdata;
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_hdr || cmd_i.load_num || cmd_i.load_name) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_hdr) begin
      out_data_q <= hdr_data;
      out_kind_q <= ItemHeader;
      out_last_q <= !status_o.num_any && !status_o.name_any;
    end else if (cmd_i.load_num) begin
      out_data_q <= chr_data;
      out_kind_q <= ItemNumber;
      out_last_q <= !status_o.num_more && !status_o.name_any;
    end else if (cmd_i.load_name) begin
      out_data_q <= chr_data;
      out_kind_q <= ItemName;
      out_last_q <= !status_o.name_more;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_kind_o  = out_kind_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== rtl/core/cidlp_ctrl.sv =====
// Sequencer of the caller-ID line parser: input handshake and record emission.
// Uses cidlp_pkg; drives cidlp_datapath through command and status structs.
`timescale 1ns / 1ps

module cidlp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  cidlp_pkg::dp_status_t status_i,
  output cidlp_pkg::dp_cmd_t    cmd_o
);

  import cidlp_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_HDR     = 6'b000010,
    ST_NUM_RD  = 6'b000100,
    ST_NUM_LD  = 6'b001000,
    ST_NAME_RD = 6'b010000,
    ST_NAME_LD = 6'b100000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && status_i.rec_end) begin
          state_d = ST_HDR;
        end
      end
      ST_HDR: begin
        if (status_i.out_free) begin
          cmd_o.load_hdr = 1'b1;
          cmd_o.idx_clr  = 1'b1;
          if (status_i.num_any) begin
            state_d = ST_NUM_RD;
          end else if (status_i.name_any) begin
            state_d = ST_NAME_RD;
          end else begin
            cmd_o.clear_fields = 1'b1;
            state_d            = ST_IDLE;
          end
        end
      end
      ST_NUM_RD: begin
        cmd_o.rd_num = 1'b1;
        state_d      = ST_NUM_LD;
      end
      ST_NUM_LD: begin
        if (status_i.out_free) begin
          cmd_o.load_num = 1'b1;
          if (status_i.num_more) begin
            cmd_o.idx_inc = 1'b1;
            state_d       = ST_NUM_RD;
          end else begin
            cmd_o.idx_clr = 1'b1;
            if (status_i.name_any) begin
              state_d = ST_NAME_RD;
            end else begin
              cmd_o.clear_fields = 1'b1;
              state_d            = ST_IDLE;
            end
          end
        end
      end
      ST_NAME_RD: begin
        cmd_o.rd_name = 1'b1;
        state_d       = ST_NAME_LD;
      end
      ST_NAME_LD: begin
        if (status_i.out_free) begin
          cmd_o.load_name = 1'b1;
          if (status_i.name_more) begin
            cmd_o.idx_inc = 1'b1;
            state_d       = ST_NAME_RD;
          end else begin
            cmd_o.idx_clr      = 1'b1;
            cmd_o.clear_fields = 1'b1;
            state_d            = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== tb/tb_caller_id_line_parser.sv =====
// Self-checking testbench for the caller-ID line parser.
// Streams modem text lines into caller_id_line_parser and checks each record item
// against a line parser kept inside the bench. Depends on cidlp_pkg and the block RTL.
`timescale 1ns / 1ps

module tb_caller_id_line_parser;
  import cidlp_pkg::*;

  localparam int unsigned NumChars   = NumberCharsDef;
  localparam int unsigned NameChars  = NameCharsDef;
  localparam int unsigned StallLimit = 400;
  localparam int unsigned MaxReports = 10;

  // one record item as it leaves the output stream
  typedef struct packed {
    logic [ItemKindW-1:0] kind;
    logic                 last;
    out_data_t            data;
  } rec_item_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [LineIdW-1:0]   cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [ByteW-1:0]     s_axis_tdata  = '0;  // rx_byte
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;        // record fields, line_number lowest
  logic [ItemKindW-1:0] m_axis_tuser;        // item_kind
  logic                 m_axis_tlast;        // last_of_record

  // modem bytes waiting to be sent, record items still to arrive
  logic [ByteW-1:0] rx_bytes_q[$];
  rec_item_t        record_q[$];

  int unsigned err_count   = 0;
  int unsigned idle_odds   = 0;
  int unsigned in_gap      = 0;
  int unsigned out_gap     = 0;
  int unsigned quiet_count = 0;

  // line parser state kept by the bench
  logic [LineIdW-1:0] line_id_copy = LineIdReset;
  int unsigned        ln_len       = 0;
  logic [23:0]        kw_bytes     = '0;
  line_kind_e         ln_kind      = KIND_NONE;
  logic               skip_done    = 1'b0;
  logic [31:0]        date_txt     = '0;
  logic [31:0]        time_txt     = '0;
  int unsigned        date_cnt     = 0;
  int unsigned        time_cnt     = 0;
  int unsigned        num_cnt      = 0;
  int unsigned        num_kept     = 0;
  int unsigned        nm_cnt       = 0;
  int unsigned        nm_kept      = 0;
  logic [7:0]         num_buf [NumChars];
  logic [7:0]         nm_buf [NameChars];

  caller_id_line_parser i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 100 MHz clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // advance the line parser by one byte, queue the record a NAME line releases
  task automatic parse_rx_byte(input logic [7:0] c);
    logic [31:0] word;
    rec_item_t   it;
    logic        keep;
    if (c == CharLf || c == CharNul) begin
      if (ln_len != 0 && ln_kind == KIND_NAME) begin
        it                    = '0;
        it.kind               = ItemHeader;
        it.last               = (num_kept + nm_kept == 0);
        it.data.line_number   = line_id_copy;
        it.data.date_text     = date_txt;
        it.data.date_length   = date_cnt[TextLenW-1:0];
        it.data.time_text     = time_txt;
        it.data.time_length   = time_cnt[TextLenW-1:0];
        it.data.number_length = num_kept[NumLenW-1:0];
        it.data.name_length   = nm_kept[NameLenW-1:0];
        record_q.push_back(it);
        for (int i = 0; i < int'(num_kept); i++) begin
          it                = '0;
          it.kind           = ItemNumber;
          it.data.text_char = num_buf[i];
          it.last           = (nm_kept == 0) && (i == int'(num_kept) - 1);
          record_q.push_back(it);
        end
        for (int i = 0; i < int'(nm_kept); i++) begin
          it                = '0;
          it.kind           = ItemName;
          it.data.text_char = nm_buf[i];
          it.last           = (i == int'(nm_kept) - 1);
          record_q.push_back(it);
        end
        // a record clears every field
        date_txt = '0;
        date_cnt = 0;
        time_txt = '0;
        time_cnt = 0;
        num_cnt  = 0;
        num_kept = 0;
        nm_cnt   = 0;
        nm_kept  = 0;
      end
      ln_len    = 0;
      kw_bytes  = '0;
      ln_kind   = KIND_NONE;
      skip_done = 1'b0;
    end else begin
      if (ln_len < 3) begin
        kw_bytes = {kw_bytes[15:0], c};
      end else if (ln_len == 3) begin
        // fourth byte decides the keyword and restarts that field
        word      = {kw_bytes, c};
        skip_done = 1'b0;
        case (word)
          WordDate: begin
            ln_kind  = KIND_DATE;
            date_txt = '0;
            date_cnt = 0;
          end
          WordTime: begin
            ln_kind  = KIND_TIME;
            time_txt = '0;
            time_cnt = 0;
          end
          WordNmbr: begin
            ln_kind  = KIND_NMBR;
            num_cnt  = 0;
            num_kept = 0;
          end
          WordName: begin
            ln_kind = KIND_NAME;
            nm_cnt  = 0;
            nm_kept = 0;
          end
          default: ln_kind = KIND_NONE;
        endcase
      end else if (ln_kind != KIND_NONE) begin
        // separators, then a single leading one on number lines
        keep = 1'b1;
        if (!skip_done) begin
          if (c == CharSpace || c == CharEqual) begin
            keep = 1'b0;
          end else begin
            skip_done = 1'b1;
            if (ln_kind == KIND_NMBR && c == CharOne) keep = 1'b0;
          end
        end
        if (keep) begin
          case (ln_kind)
            KIND_DATE: begin
              if (date_cnt < 4) begin
                date_txt[31 - 8 * date_cnt -: 8] = c;
                date_cnt++;
              end
            end
            KIND_TIME: begin
              if (time_cnt < 4) begin
                time_txt[31 - 8 * time_cnt -: 8] = c;
                time_cnt++;
              end
            end
            KIND_NMBR: begin
              if (num_cnt < NumChars) begin
                num_buf[num_cnt] = c;
                num_cnt++;
                if (c != CharSpace && c != CharCr) num_kept = num_cnt;
              end
            end
            KIND_NAME: begin
              if (nm_cnt < NameChars) begin
                nm_buf[nm_cnt] = c;
                nm_cnt++;
                if (c != CharSpace && c != CharCr) nm_kept = nm_cnt;
              end
            end
            default: ;
          endcase
        end
      end
      if (ln_len < 255) ln_len++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) rx_bytes_q.push_back(s[i]);
  endtask

  // mostly digits and capitals, some spaces, CRs and arbitrary bytes
  function automatic logic [7:0] rand_text_byte();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0:       c = CharSpace;
      1:       c = CharCr;
      2:       c = 8'($urandom_range(1, 255));
      default: c = 8'($urandom_range(8'h30, 8'h5A));
    endcase
    if (c == CharLf) c = CharSpace;
    return c;
  endfunction

  task automatic push_line_end();
    rx_bytes_q.push_back(($urandom_range(0, 4) == 0) ? CharNul : CharLf);
  endtask

  // keyword, separators, optional leading one, content, line end
  task automatic push_field_line(input logic [31:0] word, input int unsigned n);
    for (int i = 3; i >= 0; i--) rx_bytes_q.push_back(word[8 * i +: 8]);
    repeat ($urandom_range(0, 3))
      rx_bytes_q.push_back($urandom_range(0, 1) ? CharSpace : CharEqual);
    if (word == WordNmbr && $urandom_range(0, 1) == 1) rx_bytes_q.push_back(CharOne);
    repeat (n) rx_bytes_q.push_back(rand_text_byte());
    push_line_end();
  endtask

  // garbage, corrupted keywords and truncated keywords
  task automatic push_noise_line();
    logic [31:0] word;
    logic [7:0]  c;
    int unsigned k;
    case ($urandom_range(0, 3))
      0:       word = WordDate;
      1:       word = WordTime;
      2:       word = WordNmbr;
      default: word = WordName;
    endcase
    case ($urandom_range(0, 2))
      0: begin
        repeat ($urandom_range(0, 8)) begin
          c = 8'($urandom_range(1, 255));
          if (c == CharLf) c = 8'hF5;
          rx_bytes_q.push_back(c);
        end
      end
      1: begin
        word[$urandom_range(0, 31)] ^= 1'b1;
        for (int i = 3; i >= 0; i--) rx_bytes_q.push_back(word[8 * i +: 8]);
        repeat ($urandom_range(0, 4)) rx_bytes_q.push_back(rand_text_byte());
      end
      default: begin
        k = $urandom_range(1, 3);
        for (int i = 0; i < int'(k); i++) rx_bytes_q.push_back(word[31 - 8 * i -: 8]);
      end
    endcase
    push_line_end();
  endtask

  // field lines in any order and number, then the NAME line that releases a record
  task automatic push_caller_record();
    logic [31:0] word;
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 2))
        0:       word = WordDate;
        1:       word = WordTime;
        default: word = WordNmbr;
      endcase
      if (word == WordNmbr)
        push_field_line(word, ($urandom_range(0, 9) == 0) ? $urandom_range(15, 20)
                                                          : $urandom_range(0, 12));
      else
        push_field_line(word, $urandom_range(0, 6));
      if ($urandom_range(0, 5) == 0) push_noise_line();
    end
    push_field_line(WordName, ($urandom_range(0, 9) == 0) ? $urandom_range(50, 60)
                                                         : $urandom_range(0, 16));
  endtask

  task automatic push_random_traffic(input int unsigned budget);
    while (rx_bytes_q.size() < budget) begin
      if ($urandom_range(0, 3) == 0) push_noise_line();
      else push_caller_record();
    end
  endtask

  // wait until every byte is taken and every record item has arrived
  task automatic settle();
    while (rx_bytes_q.size() != 0 || s_axis_tvalid || record_q.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_line_id(input logic [LineIdW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    line_id_copy = v;
  endtask

  // ---------------------------------------------------------------------------
  // sequence of phases

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni    <= 1'b1;
    idle_odds = 2;

    // directed lines, line id still at its reset value
    push_text("\n\n");
    push_text("NAME\n");
    push_text("AB\n");
    push_text("DATE=0412\015\n");
    push_text("TIME==9");
    rx_bytes_q.push_back(CharNul);
    push_text("NMBR  1 555 0199  \015\n");
    push_text("NAME=JOHN \015\n");
    push_text("NMBR=11\n");
    push_text("NAMEx");
    rx_bytes_q.push_back(8'hFF);
    rx_bytes_q.push_back(8'h80);
    rx_bytes_q.push_back(8'h01);
    push_text("\n");
    push_text("DATE1234567\n");
    // overlong number and name get cut to the store sizes
    push_text("NMBR=");
    for (int i = 0; i < 16; i++) rx_bytes_q.push_back(8'(48 + i % 10));
    push_text("\n");
    push_text("NAME ");
    for (int i = 0; i < 50; i++) rx_bytes_q.push_back(8'(65 + i % 26));
    push_text("\n");
    // number of only the leading one, name of only a CR
    push_text("NMBR1\n");
    push_text("NAME\015\n");
    settle();

    write_line_id(5'd16);
    idle_odds = 3;
    push_random_traffic(20);
    settle();

    write_line_id(5'($urandom_range(2, 15)));
    idle_odds = 1;
    push_random_traffic(20);
    settle();

    // closing stretch at full rate on both sides
    write_line_id(5'd1);
    idle_odds = 0;
    push_random_traffic(20);
    settle();
    repeat (12) @(posedge clk_i);

    if (err_count == 0 && record_q.size() == 0) begin
      $display("caller_id_line_parser regression: pass");
    end else begin
      $display("caller_id_line_parser regression: fail");
    end
    $finish;
  end

  // input driver: bytes from the pending queue, random gaps
  always @(posedge clk_i) begin
    logic next_valid;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      next_valid = 1'b0;
      if (in_gap != 0) begin
        in_gap--;
      end else if (rx_bytes_q.size() != 0) begin
        if ($urandom_range(0, 9) < idle_odds) begin
          in_gap = $urandom_range(0, 4);
        end else begin
          next_valid = 1'b1;
          s_axis_tdata <= rx_bytes_q.pop_front();
        end
      end
      s_axis_tvalid <= next_valid;
    end
  end

  // monitor: check record items, track accepted bytes, stall the output
  always @(posedge clk_i) begin
    rec_item_t got;
    rec_item_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = m_axis_tuser;
        got.last = m_axis_tlast;
        got.data = m_axis_tdata;
        if (record_q.size() == 0) begin
          err_count++;
          if (err_count <= MaxReports)
            $display("unexpected item: kind %0d last %0b data %h",
                     got.kind, got.last, got.data);
        end else begin
          want = record_q.pop_front();
          if (got.kind !== want.kind || got.last !== want.last ||
              got.data.line_number !== want.data.line_number ||
              got.data.date_text !== want.data.date_text ||
              got.data.date_length !== want.data.date_length ||
              got.data.time_text !== want.data.time_text ||
              got.data.time_length !== want.data.time_length ||
              got.data.number_length !== want.data.number_length ||
              got.data.name_length !== want.data.name_length ||
              got.data.text_char !== want.data.text_char ||
              got.data.pad !== want.data.pad) begin
            err_count++;
            if (err_count <= MaxReports)
              $display("item mismatch: expected kind %0d last %0b data %h, %s",
                       want.kind, want.last, want.data,
                       $sformatf("got kind %0d last %0b data %h",
                                 got.kind, got.last, got.data));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) parse_rx_byte(s_axis_tdata);
      // receiver stall bursts
      if (out_gap != 0) begin
        out_gap--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 9) < idle_odds) begin
        out_gap = $urandom_range(0, 4);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_count <= 0;
    end else if (quiet_count == StallLimit) begin
      $display("caller_id_line_parser regression: fail");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

endmodule

// ===== files.f =====
rtl/core/cidlp_pkg.sv
rtl/core/cidlp_ram.sv
rtl/core/cidlp_datapath.sv
rtl/core/cidlp_ctrl.sv
rtl/core/caller_id_line_parser.sv
tb/tb_caller_id_line_parser.sv
